// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the response frame parser.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/srfp_pkg.sv =====
// Shared types and constants for the servo response frame parser.
// No dependencies.
package srfp_pkg;

    localparam logic [7:0] HDR_BYTE = 8'h55;
    localparam logic [7:0] ANY_ID   = 8'hFE;
    localparam logic [7:0] LEN_MIN  = 8'd3;
    localparam logic [7:0] LEN_MAX  = 8'd7;

    localparam logic [3:0] POS_RESET = 4'd0;
    localparam logic [3:0] LEN_RESET = 4'd7;
    localparam logic [3:0] POS_LAST  = 4'd9;

    localparam logic [7:0] EXP_ID_RESET  = 8'hFE;
    localparam logic [7:0] EXP_CMD_RESET = 8'h00;
    localparam logic [2:0] MAX_PAR_RESET = 3'd4;

    typedef enum logic [1:0] {
        REG_EXPECTED_ID      = 2'd0,
        REG_EXPECTED_COMMAND = 2'd1,
        REG_MAX_PARAMS       = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_BUSY     = 4'd0,
        ST_OK       = 4'd1,
        ST_HEADER   = 4'd2,
        ST_ID       = 4'd3,
        ST_LENGTH   = 4'd4,
        ST_TOOLONG  = 4'd5,
        ST_COMMAND  = 4'd6,
        ST_CHECKSUM = 4'd7,
        ST_ABORTED  = 4'd8
    } status_t;

    typedef struct packed {
        logic [7:0] expected_id;
        logic [7:0] expected_command;
        logic [2:0] max_params;
    } cfg_t;

    typedef struct packed {
        status_t    status;
        logic       param_valid;
        logic [1:0] param_index;
        logic [7:0] param_value;
    } result_t;

    typedef struct packed {
        logic [3:0] byte_position;
        logic [3:0] frame_length;
        logic [7:0] running_sum;
    } parse_state_t;

endpackage

// ===== rtl/core/srfp_parse.sv =====
// Per-beat frame check and parser state registers.
// Depends on srfp_pkg.
module srfp_parse
    import srfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_en,
    input  logic         beat_abort,
    input  logic [7:0]   beat_byte,
    input  cfg_t         cfg,
    output result_t      result,
    output parse_state_t state
);

    logic [3:0] pos_reg, pos_next;
    logic [3:0] len_reg, len_next;
    logic [7:0] sum_reg, sum_next;
    logic       done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_RESET;
            len_reg <= LEN_RESET;
            sum_reg <= 8'd0;
        end else if (step_en) begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            sum_reg <= sum_next;
        end
    end

    always_comb begin
        result.status      = ST_BUSY;
        result.param_valid = 1'b0;
        result.param_index = 2'd0;
        result.param_value = 8'd0;
        done     = 1'b0;
        pos_next = pos_reg;
        len_next = len_reg;
        sum_next = sum_reg;

        if (beat_abort) begin
            result.status = ST_ABORTED;
            done = 1'b1;
        end else if (pos_reg <= 4'd1) begin
            if (beat_byte != HDR_BYTE) begin
                result.status = ST_HEADER;
                done = 1'b1;
            end
        end else if (pos_reg == 4'd2) begin
            if (beat_byte != cfg.expected_id && cfg.expected_id != ANY_ID) begin
                result.status = ST_ID;
                done = 1'b1;
            end
        end else if (pos_reg == 4'd3) begin
            if (beat_byte < LEN_MIN || beat_byte > LEN_MAX) begin
                result.status = ST_LENGTH;
                done = 1'b1;
            end else if ({1'b0, beat_byte[2:0]} > ({1'b0, cfg.max_params} + 4'd3)) begin
                // length + 3 > max_params + 6, compared without the common offset
                result.status = ST_TOOLONG;
                done = 1'b1;
            end else begin
                len_next = {1'b0, beat_byte[2:0]} + 4'd3;
            end
        end else if (pos_reg == 4'd4) begin
            if (beat_byte != cfg.expected_command) begin
                result.status = ST_COMMAND;
                done = 1'b1;
            end
        end else if (({1'b0, pos_reg} + 5'd1) >= {1'b0, len_reg}) begin
            result.status = (beat_byte == ~sum_reg) ? ST_OK : ST_CHECKSUM;
            done = 1'b1;
        end else begin
            result.param_valid = 1'b1;
            result.param_index = pos_reg[1:0] + 2'd3;   // (pos - 5) mod 4
            result.param_value = beat_byte;
        end

        if (!done) begin
            if (pos_reg >= 4'd2) begin
                sum_next = sum_reg + beat_byte;
            end
            pos_next = pos_reg + 4'd1;
        end else begin
            pos_next = POS_RESET;
            len_next = LEN_RESET;
            sum_next = 8'd0;
        end
    end

    assign state.byte_position = pos_reg;
    assign state.frame_length  = len_reg;
    assign state.running_sum   = sum_reg;

endmodule

// ===== rtl/core/srfp_out_stage.sv =====
// Result register of the parser: holds one result beat until the sink takes it.
// Depends on srfp_pkg.
module srfp_out_stage
    import srfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result_in,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t result_out,
    output logic    advance
);

    logic    valid_reg;
    result_t data_reg;

    // The stage can take a new result when empty or when its beat leaves now.
    assign advance = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && load) begin
            data_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

// ===== rtl/core/servo_response_frame_parser.sv =====
// Servo response frame parser: top level with input register, configuration
// registers and assertions. Depends on srfp_pkg, srfp_parse, srfp_out_stage.
//
// Checks reply frames of a half-duplex servo bus one received byte per beat:
// two 0x55 header bytes, id (0xFE in expected_id accepts any id), length 3..7
// limited by max_params, the expected command, parameter bytes, then the
// inverted 8-bit sum of id through last parameter. Every input beat yields
// exactly one result beat: status busy while a frame is in progress (with the
// parameter byte and its index when param_valid is set), or the final verdict,
// after which the parser waits for a header again. An input beat with the abort
// flag set in s_tuser stands for the bus timeout and answers status aborted.
// Throughput is one beat per clock while the sink does not stall. A beat passes
// an input register and a result register with the combinational frame check
// between them; that check closes the position/length/sum loop combinationally,
// which sets the rate. The user must write configuration only while no beat
// is in flight; the block does not enforce this. Reset has no clearing pass.
module servo_response_frame_parser
    import srfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] cmd (1 = abort)

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] status, [5:4] param_index, [13:6] param_value, zero pad
    output logic [0:0]  m_tuser    // [0] param_valid
);

`include "assert_macros.svh"

    // Configuration registers
    logic [7:0] exp_id_reg;
    logic [7:0] exp_cmd_reg;
    logic [2:0] max_par_reg;
    cfg_t       cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_id_reg  <= EXP_ID_RESET;
            exp_cmd_reg <= EXP_CMD_RESET;
            max_par_reg <= MAX_PAR_RESET;
        end else if (cfg_we) begin
            // write to an index past the list is dropped
            unique case (cfg_index)
                REG_EXPECTED_ID:      exp_id_reg  <= cfg_wdata;
                REG_EXPECTED_COMMAND: exp_cmd_reg <= cfg_wdata;
                REG_MAX_PARAMS:       max_par_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    assign cfg.expected_id      = exp_id_reg;
    assign cfg.expected_command = exp_cmd_reg;
    assign cfg.max_params       = max_par_reg;

    // Input register: hold one beat until the result stage can take its result
    logic       in_valid_reg;
    logic       in_abort_reg;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       step_fire;
    logic       s_fire;

    assign s_tready  = !in_valid_reg || advance;
    assign s_fire    = s_tvalid && s_tready;
    assign step_fire = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_abort_reg <= s_tuser[0];
            in_byte_reg  <= s_tdata;
        end
    end

    // Frame check; parser state advances only when the result moves on
    result_t      step_result;
    parse_state_t pstate;

    srfp_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_fire),
        .beat_abort (in_abort_reg),
        .beat_byte  (in_byte_reg),
        .cfg        (cfg),
        .result     (step_result),
        .state      (pstate)
    );

    // Result register toward the sink
    result_t out_result;

    srfp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (in_valid_reg),
        .result_in  (step_result),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .result_out (out_result),
        .advance    (advance)
    );

    assign m_tdata = {2'b00, out_result.param_value, out_result.param_index,
                      out_result.status};
    assign m_tuser = out_result.param_valid;

    // Parser sits at its reset point, waiting for the first header byte
    logic parse_at_rest;

    assign parse_at_rest = (pstate.byte_position == POS_RESET)
                        && (pstate.frame_length == LEN_RESET)
                        && (pstate.running_sum == 8'd0);

    // A parameter beat never carries a final verdict
    `ASSERT_IMPLIES(a_param_busy, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[3:0] == ST_BUSY)
    // An abort step leaves the parser waiting for the first header byte
    `ASSERT_NEXT(a_abort_restart, aclk, aresetn, step_fire && in_abort_reg, parse_at_rest)
    // The position never runs past the checksum of the longest frame
    `ASSERT_IMPLIES(a_pos_bound, aclk, aresetn, 1'b1, pstate.byte_position <= POS_LAST)

endmodule

// ===== test/frame_check.sv =====
// Watches both streams of the servo response frame parser, predicts each result beat
// and compares it with the block's output. Depends on srfp_pkg only.
module frame_check
    import srfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_tuser,   // [0] cmd (1 = abort)
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [3:0] status, [5:4] param_index, [13:6] param_value
    input  logic [0:0]  m_tuser,   // [0] param_valid
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 200;

    logic [7:0] want_id;
    logic [7:0] want_cmd;
    logic [2:0] param_limit;

    logic [3:0] pos;
    logic [3:0] frame_len;
    logic [7:0] byte_sum;

    result_t awaited_results[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic result_t predict_parse(input logic abort, input logic [7:0] b);
        result_t r;
        logic    done;
        r = '0;
        r.status = ST_BUSY;
        done = 1'b0;
        if (abort) begin
            r.status = ST_ABORTED;
            done = 1'b1;
        end else if (pos <= 4'd1) begin
            if (b != HDR_BYTE) begin
                r.status = ST_HEADER;
                done = 1'b1;
            end
        end else if (pos == 4'd2) begin
            if (b != want_id && want_id != ANY_ID) begin
                r.status = ST_ID;
                done = 1'b1;
            end
        end else if (pos == 4'd3) begin
            if (b < LEN_MIN || b > LEN_MAX) begin
                r.status = ST_LENGTH;
                done = 1'b1;
            end else if (int'(b) + 3 > int'(param_limit) + 6) begin
                r.status = ST_TOOLONG;
                done = 1'b1;
            end else begin
                frame_len = 4'(b + 8'd3);
            end
        end else if (pos == 4'd4) begin
            if (b != want_cmd) begin
                r.status = ST_COMMAND;
                done = 1'b1;
            end
        end else if (int'(pos) + 1 >= int'(frame_len)) begin
            // anything at or past the last slot is taken as the checksum
            r.status = (b == ~byte_sum) ? ST_OK : ST_CHECKSUM;
            done = 1'b1;
        end else begin
            r.param_valid = 1'b1;
            r.param_index = 2'(pos - 4'd5);
            r.param_value = b;
        end
        if (done) begin
            pos       = POS_RESET;
            frame_len = LEN_RESET;
            byte_sum  = 8'd0;
        end else begin
            if (pos >= 4'd2)
                byte_sum = byte_sum + b;
            pos = pos + 4'd1;
        end
        return r;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            want_id     = EXP_ID_RESET;
            want_cmd    = EXP_CMD_RESET;
            param_limit = MAX_PAR_RESET;
            pos         = POS_RESET;
            frame_len   = LEN_RESET;
            byte_sum    = 8'd0;
            awaited_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_EXPECTED_ID:      want_id     = cfg_wdata;
                    REG_EXPECTED_COMMAND: want_cmd    = cfg_wdata;
                    REG_MAX_PARAMS:       param_limit = cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(predict_parse(s_tuser[0], s_tdata));
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t ns: status expected none, got %0d", $time, m_tdata[3:0]);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, m_tdata[3:0]);
                    check_field("param_valid", want.param_valid, m_tuser[0]);
                    check_field("param_index", want.param_index, m_tdata[5:4]);
                    check_field("param_value", want.param_value, m_tdata[13:6]);
                end
            end
        end
        pending = awaited_results.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Stimulus and verdict for the servo response frame parser: drives reply frames,
// register writes and random stalls; frame_check does the predicting.
// Depends on srfp_pkg, servo_response_frame_parser and frame_check.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srfp_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 240;
    localparam int LONG_HOLD   = 300;   // receiver hold-off, in cycles
    localparam int DRAIN       = 16;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] rx_byte
    logic [0:0]  s_tuser   = '0;   // [0] cmd (1 = abort)
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [3:0] status, [5:4] param_index, [13:6] param_value
    logic [0:0]  m_tuser;          // [0] param_valid

    int fail_count;
    int pending;

    // Register values as last written; frames are built to match them.
    logic [7:0] cur_id  = EXP_ID_RESET;
    logic [7:0] cur_cmd = EXP_CMD_RESET;
    logic [2:0] cur_max = MAX_PAR_RESET;

    int unsigned s_gap_max = 0;
    int unsigned m_gap_max = 0;
    logic        long_hold = 1'b0;
    int unsigned sent      = 0;

    servo_response_frame_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    frame_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs on either handshake.
    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Offer one beat after a random gap and hold it until accepted. Valid stays
    // high on return so back-to-back beats need no extra edge.
    task automatic send_byte(input logic abort, input logic [7:0] b);
        int unsigned gap;
        gap = $urandom_range(0, s_gap_max);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= abort;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // Send one reply frame; the checksum is xored with sum_flip to corrupt it.
    // A nonzero cut sends at most that many bytes and then an abort beat.
    task automatic send_reply(input logic [7:0] id_b, input logic [7:0] len_b,
                              input logic [7:0] cmd_b, input int unsigned np,
                              input logic [31:0] pw, input logic [7:0] sum_flip,
                              input int unsigned cut);
        logic [7:0]  fr[$];
        logic [7:0]  sum;
        int unsigned i;
        int unsigned n;
        fr = {HDR_BYTE, HDR_BYTE, id_b, len_b, cmd_b};
        sum = id_b + len_b + cmd_b;
        for (i = 0; i < np; i++) begin
            fr.push_back(pw[8*i +: 8]);
            sum = sum + pw[8*i +: 8];
        end
        fr.push_back(~sum ^ sum_flip);
        n = (cut != 0 && cut < fr.size()) ? cut : fr.size();
        for (i = 0; i < n; i++)
            send_byte(1'b0, fr[i]);
        if (cut != 0)
            send_byte(1'b1, 8'($urandom));
    endtask

    // Mostly clean frames with random content; the rest carry at most one defect each,
    // or are a header mismatch, or noise followed by an abort to resync.
    task automatic send_random_reply();
        int unsigned pick;
        int unsigned np;
        int unsigned cut;
        logic [7:0]  id_b;
        logic [7:0]  len_b;
        logic [7:0]  cmd_b;
        logic [7:0]  flip;
        logic [7:0]  b;
        logic        bad_len;
        np      = $urandom_range(0, (cur_max > 3'd4) ? 4 : int'(cur_max));
        id_b    = (cur_id == ANY_ID) ? 8'($urandom) : cur_id;
        cmd_b   = cur_cmd;
        flip    = 8'd0;
        cut     = 0;
        bad_len = 1'b0;
        pick    = $urandom_range(0, 99);
        if (pick < 62) begin
            // clean frame
        end else if (pick < 67) begin
            if (cur_id != ANY_ID)
                id_b = cur_id ^ 8'($urandom_range(1, 255));
        end else if (pick < 72) begin
            bad_len = 1'b1;
        end else if (pick < 76) begin
            if (cur_max < 3'd4)
                np = $urandom_range(int'(cur_max) + 1, 4);
        end else if (pick < 81) begin
            cmd_b = cur_cmd ^ 8'($urandom_range(1, 255));
        end else if (pick < 86) begin
            flip = 8'($urandom_range(1, 255));
        end else if (pick < 91) begin
            cut = $urandom_range(1, np + 5);
        end else if (pick < 96) begin
            // header mismatch at the first or the second header slot
            b = 8'($urandom);
            if (b == HDR_BYTE)
                b = 8'hD5;
            if ($urandom_range(0, 1))
                send_byte(1'b0, HDR_BYTE);
            send_byte(1'b0, b);
            return;
        end else begin
            repeat ($urandom_range(0, 4)) send_byte(1'b0, 8'($urandom));
            send_byte(1'b1, 8'($urandom));
            return;
        end
        if (bad_len)
            len_b = $urandom_range(0, 1) ? 8'($urandom_range(0, 2))
                                         : 8'($urandom_range(8, 255));
        else
            len_b = 8'(np + 3);
        send_reply(id_b, len_b, cmd_b, np, $urandom, flip, cut);
    endtask

    // Write all three registers on consecutive edges while the block is idle.
    task automatic write_config(input logic [7:0] id_v, input logic [7:0] cmd_v,
                                input logic [2:0] max_v);
        cfg_we    <= 1'b1;
        cfg_index <= REG_EXPECTED_ID;
        cfg_wdata <= id_v;
        @(posedge aclk);
        cfg_index <= REG_EXPECTED_COMMAND;
        cfg_wdata <= cmd_v;
        @(posedge aclk);
        cfg_index <= REG_MAX_PARAMS;
        cfg_wdata <= {5'd0, max_v};
        @(posedge aclk);
        cfg_we  <= 1'b0;
        cur_id  = id_v;
        cur_cmd = cmd_v;
        cur_max = max_v;
    endtask

    // Drop valid and wait for every predicted result to drain. Sample on the
    // falling edge so the checker's count has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Result side: random stall per beat, plus one long hold-off on request
    // that backs the block up into its input.
    initial begin
        int unsigned stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            stall = $urandom_range(0, m_gap_max);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        int unsigned ph;
        int unsigned start;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats under the reset register values (any id, command 0,
        // up to four parameters).
        s_gap_max = 2;
        m_gap_max = 2;
        send_byte(1'b1, 8'hFF);                          // abort while waiting
        send_byte(1'b0, 8'hAA);                          // junk at first header slot
        send_byte(1'b0, HDR_BYTE);                       // header, then junk at second header slot
        send_byte(1'b0, 8'h00);
        send_reply(8'hFF, 8'd7, 8'h00, 4, 32'h7F80_00FF, 8'h00, 0);  // longest reply
        send_reply(8'h00, 8'd3, 8'h00, 0, 32'h0, 8'h00, 0);          // no parameters
        send_reply(8'h00, 8'd2, 8'h00, 0, 32'h0, 8'h00, 4);          // length too short
        wait_idle();

        // Random phases, each under its own register setting and idle pattern.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    write_config(ANY_ID, 8'h00, 3'd4);
                    s_gap_max = 10;
                    m_gap_max = 10;
                end
                1: begin
                    write_config(8'h00, 8'hFF, 3'd0);
                    s_gap_max = 10;
                    m_gap_max = 10;
                end
                2: begin
                    write_config(8'hFF, 8'h00, 3'd7);
                    s_gap_max = 3;
                    m_gap_max = 10;
                end
                3: begin
                    write_config(8'($urandom_range(0, 253)), 8'($urandom), 3'd5);
                    s_gap_max = 10;
                    m_gap_max = 3;
                end
                4: begin
                    write_config(ANY_ID, 8'($urandom), 3'($urandom_range(1, 3)));
                    s_gap_max = 10;
                    m_gap_max = 10;
                end
                5: begin
                    // Sender streams flat out while the receiver holds off.
                    write_config(8'h01, 8'h1C, 3'd2);
                    s_gap_max = 0;
                    m_gap_max = 10;
                    long_hold = 1'b1;
                end
                6: begin
                    write_config(8'($urandom), 8'($urandom), 3'd6);
                    s_gap_max = 10;
                    m_gap_max = 10;
                end
                default: begin
                    write_config(8'($urandom), 8'($urandom), 3'($urandom_range(0, 4)));
                    s_gap_max = 0;
                    m_gap_max = 0;
                end
            endcase
            start = sent;
            while (sent - start < PHASE_BEATS)
                send_random_reply();
            wait_idle();
        end

        repeat (DRAIN) @(posedge aclk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
